>>> design/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Types, codes and the LED pattern table shared by the button debounce and
// LED pattern block.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int unsigned DbW     = 7;
  localparam int unsigned MsW     = 16;
  localparam int unsigned TickW   = 7;
  localparam int unsigned PhaseW  = 11;
  localparam int unsigned BlinkW  = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic [DbW-1:0]    SameMax  = 7'd100;
  localparam logic [PhaseW-1:0] PhaseMax = 11'd2047;
  localparam logic [MsW-1:0]    PressMax = 16'hFFFF;

  localparam logic [DbW-1:0]   DebounceReset = 7'd3;
  localparam logic [MsW-1:0]   LongReset     = 16'd2000;
  localparam logic [MsW-1:0]   MinReset      = 16'd50;
  localparam logic [TickW-1:0] TickReset     = 7'd20;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOCAL_ACKED,
    ST_SENDING,
    ST_ACCEPTED,
    ST_ANSWERED,
    ST_CANCELLED,
    ST_FAILED
  } state_e;

  localparam logic [2:0] NumStates = 3'd7;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_REQUEST,
    ACT_CANCEL,
    ACT_RESEND
  } action_e;

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_ON,
    MODE_BLINK
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE,
    CFG_LONG_PRESS,
    CFG_MIN_PRESS,
    CFG_TICK
  } cfg_idx_e;

  typedef struct packed {
    mode_e             mode;
    logic [PhaseW-1:0] on_ms;
    logic [PhaseW-1:0] off_ms;
    logic [BlinkW-1:0] times;
  } pattern_t;

  typedef struct packed {
    logic [DbW-1:0]   debounce_samples;
    logic [MsW-1:0]   long_press_ms;
    logic [MsW-1:0]   min_press_ms;
    logic [TickW-1:0] tick_ms;
  } cfg_t;

  typedef struct packed {
    cmd_e       command;
    logic       raw_level;
    logic [2:0] new_state;
  } item_t;

  typedef struct packed {
    logic   led_lit;
    state_e state;
    logic   changed;
  } led_res_t;

  function automatic pattern_t pattern_of(state_e st);
    pattern_t p;
    case (st)
      ST_IDLE:        p = '{MODE_OFF,   11'd0,   11'd0,   4'd0};
      ST_LOCAL_ACKED: p = '{MODE_BLINK, 11'd150, 11'd850, 4'd0};
      ST_SENDING:     p = '{MODE_BLINK, 11'd100, 11'd100, 4'd0};
      ST_ACCEPTED:    p = '{MODE_ON,    11'd0,   11'd0,   4'd0};
      ST_ANSWERED:    p = '{MODE_BLINK, 11'd120, 11'd120, 4'd6};
      ST_CANCELLED:   p = '{MODE_BLINK, 11'd400, 11'd400, 4'd4};
      ST_FAILED:      p = '{MODE_BLINK, 11'd80,  11'd80,  4'd10};
      default:        p = '{MODE_OFF,   11'd0,   11'd0,   4'd0};
    endcase
    return p;
  endfunction

endpackage

>>> design/bdlp_ifs.sv
// ----------------------------------------------------------------------------
// bdlp channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface bdlp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic       raw_level;
  logic [2:0] new_state;

  modport source (output valid, command, raw_level, new_state, input ready);
  modport sink (input valid, command, raw_level, new_state, output ready);
endinterface

interface bdlp_out_if;
  logic       valid;
  logic       ready;
  logic       led_lit;
  logic [1:0] action;
  logic [2:0] current_state;
  logic       state_changed;

  modport source (output valid, led_lit, action, current_state, state_changed,
                  input ready);
  modport sink (input valid, led_lit, action, current_state, state_changed,
                output ready);
endinterface

>>> design/bdlp_press.sv
// ----------------------------------------------------------------------------
// bdlp_press
// Button debounce, press timer and press classification.
// ----------------------------------------------------------------------------
module bdlp_press (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  bdlp_pkg::item_t     item_i,
  input  bdlp_pkg::cfg_t      cfg_i,
  input  logic                idle_i,
  output bdlp_pkg::action_e   action_o
);

  logic                        last_q, last_d;
  logic                        stable_q, stable_d;
  logic [bdlp_pkg::DbW-1:0]    same_q, same_d;
  logic [bdlp_pkg::MsW-1:0]    press_q, press_d;
  logic [bdlp_pkg::MsW:0]      press_sum;
  logic [bdlp_pkg::MsW-1:0]    press_cur;
  logic                        level_taken;
  logic                        tick;

  assign tick = step_i && (item_i.command == bdlp_pkg::CMD_TICK);

  always_comb begin
    press_sum = {1'b0, press_q} + {{(bdlp_pkg::MsW + 1 - bdlp_pkg::TickW){1'b0}}, cfg_i.tick_ms};
    // press time only runs while the debounced level is pressed
    if (stable_q) begin
      press_cur = press_q;
    end else if (press_sum[bdlp_pkg::MsW]) begin
      press_cur = bdlp_pkg::PressMax;
    end else begin
      press_cur = press_sum[bdlp_pkg::MsW-1:0];
    end

    last_d = item_i.raw_level;
    if (item_i.raw_level != last_q) begin
      same_d = 7'd1;
    end else if (same_q < bdlp_pkg::SameMax) begin
      same_d = same_q + 7'd1;
    end else begin
      same_d = same_q;
    end

    // set commands never sample the button
    level_taken = (item_i.command == bdlp_pkg::CMD_TICK) &&
                  (same_d == cfg_i.debounce_samples) && (stable_q != item_i.raw_level);
    stable_d    = level_taken ? item_i.raw_level : stable_q;
    press_d     = (level_taken && !item_i.raw_level) ? '0 : press_cur;

    action_o = bdlp_pkg::ACT_NONE;
    if (level_taken && item_i.raw_level) begin
      if (press_cur >= cfg_i.long_press_ms) begin
        action_o = bdlp_pkg::ACT_RESEND;
      end else if (press_cur >= cfg_i.min_press_ms) begin
        action_o = idle_i ? bdlp_pkg::ACT_REQUEST : bdlp_pkg::ACT_CANCEL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b1;
      stable_q <= 1'b1;
      same_q   <= '0;
      press_q  <= '0;
    end else if (tick) begin
      last_q   <= last_d;
      stable_q <= stable_d;
      same_q   <= same_d;
      press_q  <= press_d;
    end
  end

endmodule

>>> design/bdlp_led.sv
// ----------------------------------------------------------------------------
// bdlp_led
// Help state register and LED pattern sequencer.
// ----------------------------------------------------------------------------
module bdlp_led (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  bdlp_pkg::item_t        item_i,
  input  logic [bdlp_pkg::TickW-1:0] tick_ms_i,
  output logic                   idle_o,
  output bdlp_pkg::led_res_t     res_o
);

  bdlp_pkg::state_e               state_q, state_d;
  logic [bdlp_pkg::PhaseW-1:0]    phase_q, phase_d;
  logic                           led_q, led_d;
  logic [bdlp_pkg::BlinkW-1:0]    blinks_q, blinks_d;
  logic [bdlp_pkg::PhaseW:0]      phase_sum;
  logic [bdlp_pkg::PhaseW-1:0]    phase_sat;
  logic [bdlp_pkg::BlinkW-1:0]    blinks_inc;
  bdlp_pkg::pattern_t             pat;
  bdlp_pkg::pattern_t             new_pat;
  bdlp_pkg::state_e               new_st;
  logic                           changed;

  assign idle_o = (state_q == bdlp_pkg::ST_IDLE);

  always_comb begin
    pat        = bdlp_pkg::pattern_of(state_q);
    new_st     = bdlp_pkg::state_e'(item_i.new_state);
    new_pat    = bdlp_pkg::pattern_of(new_st);
    phase_sum  = {1'b0, phase_q} +
                 {{(bdlp_pkg::PhaseW + 1 - bdlp_pkg::TickW){1'b0}}, tick_ms_i};
    phase_sat  = phase_sum[bdlp_pkg::PhaseW] ? bdlp_pkg::PhaseMax
                                             : phase_sum[bdlp_pkg::PhaseW-1:0];
    blinks_inc = blinks_q + 4'd1;

    state_d  = state_q;
    phase_d  = phase_q;
    led_d    = led_q;
    blinks_d = blinks_q;
    changed  = 1'b0;

    if (item_i.command == bdlp_pkg::CMD_SET) begin
      if ((item_i.new_state < bdlp_pkg::NumStates) && (new_st != state_q)) begin
        state_d  = new_st;
        phase_d  = '0;
        blinks_d = '0;
        led_d    = (new_pat.mode != bdlp_pkg::MODE_OFF);
        changed  = 1'b1;
      end
    end else begin
      phase_d = phase_sat;
      case (pat.mode)
        bdlp_pkg::MODE_OFF: begin
          led_d = 1'b0;
        end
        bdlp_pkg::MODE_ON: begin
          led_d = 1'b1;
        end
        bdlp_pkg::MODE_BLINK: begin
          if (led_q) begin
            if (phase_sat >= pat.on_ms) begin
              led_d   = 1'b0;
              phase_d = '0;
            end
          end else if (phase_sat >= pat.off_ms) begin
            // counted pattern falls back to idle after its last off phase
            if ((pat.times != '0) && (blinks_inc >= pat.times)) begin
              state_d  = bdlp_pkg::ST_IDLE;
              phase_d  = '0;
              blinks_d = '0;
              led_d    = 1'b0;
              changed  = 1'b1;
            end else begin
              if (pat.times != '0) begin
                blinks_d = blinks_inc;
              end
              led_d   = 1'b1;
              phase_d = '0;
            end
          end
        end
        default: begin
          led_d = 1'b0;
        end
      endcase
    end

    res_o.led_lit = led_d;
    res_o.state   = state_d;
    res_o.changed = changed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bdlp_pkg::ST_IDLE;
      phase_q  <= '0;
      led_q    <= 1'b0;
      blinks_q <= '0;
    end else if (step_i) begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      led_q    <= led_d;
      blinks_q <= blinks_d;
    end
  end

endmodule

>>> design/button_debounce_led_pattern.sv
// ----------------------------------------------------------------------------
// button_debounce_led_pattern
// Pipeline: an accepted item is held in the input register, its result then
// in the result register; a stall on the result side can hold it in between.
// Throughput: one item per cycle while results are taken; the debounce, press
// and LED state all update in the cycle an item moves to the result register.
// Reset: asynchronous, clears pipeline valids and the button and LED state;
// config registers return to 3, 2000, 50 and 20.
// ----------------------------------------------------------------------------
module button_debounce_led_pattern (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bdlp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bdlp_pkg::CfgW-1:0]     cfg_wdata_i,
  bdlp_in_if.sink                       item_i,
  bdlp_out_if.source                    result_o
);

  bdlp_pkg::cfg_t      cfg_q;
  logic                s1_valid_q;
  bdlp_pkg::item_t     s1_item_q;
  logic                out_valid_q;
  logic                out_led_q;
  bdlp_pkg::action_e   out_action_q;
  bdlp_pkg::state_e    out_state_q;
  logic                out_changed_q;
  logic                advance;
  logic                in_xfer;
  logic                idle;
  bdlp_pkg::action_e   action;
  bdlp_pkg::led_res_t  led_res;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_samples <= bdlp_pkg::DebounceReset;
      cfg_q.long_press_ms    <= bdlp_pkg::LongReset;
      cfg_q.min_press_ms     <= bdlp_pkg::MinReset;
      cfg_q.tick_ms          <= bdlp_pkg::TickReset;
    end else if (cfg_we_i) begin
      case (bdlp_pkg::cfg_idx_e'(cfg_idx_i))
        bdlp_pkg::CFG_DEBOUNCE:   cfg_q.debounce_samples <= cfg_wdata_i[bdlp_pkg::DbW-1:0];
        bdlp_pkg::CFG_LONG_PRESS: cfg_q.long_press_ms    <= cfg_wdata_i;
        bdlp_pkg::CFG_MIN_PRESS:  cfg_q.min_press_ms     <= cfg_wdata_i;
        bdlp_pkg::CFG_TICK:       cfg_q.tick_ms          <= cfg_wdata_i[bdlp_pkg::TickW-1:0];
        default: ;
      endcase
    end
  end

  // the result register decouples the two sides
  assign advance      = s1_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !s1_valid_q || advance;
  assign in_xfer      = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q.command   <= bdlp_pkg::cmd_e'(item_i.command);
      s1_item_q.raw_level <= item_i.raw_level;
      s1_item_q.new_state <= item_i.new_state;
    end
  end

  bdlp_press u_press (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (s1_item_q),
    .cfg_i    (cfg_q),
    .idle_i   (idle),
    .action_o (action)
  );

  bdlp_led u_led (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .item_i    (s1_item_q),
    .tick_ms_i (cfg_q.tick_ms),
    .idle_o    (idle),
    .res_o     (led_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_led_q     <= led_res.led_lit;
      out_action_q  <= action;
      out_state_q   <= led_res.state;
      out_changed_q <= led_res.changed;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.led_lit       = out_led_q;
  assign result_o.action        = out_action_q;
  assign result_o.current_state = out_state_q;
  assign result_o.state_changed = out_changed_q;

  // idle pattern never lights the LED
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_state_q == bdlp_pkg::ST_IDLE)) |-> !out_led_q)
    else $error("LED lit while idle");

  // entering any non-idle state starts with the LED on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_changed_q && (out_state_q != bdlp_pkg::ST_IDLE)) |-> out_led_q)
    else $error("state entry without LED on");

  // press events only come from tick items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (action != bdlp_pkg::ACT_NONE)) |-> (s1_item_q.command == bdlp_pkg::CMD_TICK))
    else $error("press event on a set command");

endmodule

>>> bench/bdlp_checker.sv
// ----------------------------------------------------------------------------
// bdlp_checker
// Watches the item and result channels of the button debounce and LED pattern
// block. It keeps its own copy of the debounce, press timing and LED pattern
// state, works out the expected result of every accepted item, and compares
// each accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
module bdlp_checker
  import bdlp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  bdlp_in_if                 item_i,
  bdlp_out_if                result_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SameSat  = 100;
  localparam int unsigned PressSat = 65535;
  localparam int unsigned PhaseSat = 2047;

  typedef struct packed {
    logic    led_lit;
    action_e action;
    state_e  state;
    logic    changed;
  } led_expect_t;

  led_expect_t expected_q[$];
  led_expect_t want;
  int unsigned results_seen;

  // register copies
  int unsigned db_need, long_ms, min_ms, tick_ms;

  // button and LED state
  logic        pin_last;
  int unsigned same_run;
  logic        btn_level;
  int unsigned held_ms;
  state_e      help;
  int unsigned phase_ms;
  logic        led_on;
  logic [3:0]  rounds;

  function automatic void blink_shape(input state_e st, output int unsigned on_ms,
                                      output int unsigned off_ms,
                                      output int unsigned count);
    case (st)
      ST_LOCAL_ACKED: begin on_ms = 150; off_ms = 850; count = 0;  end
      ST_SENDING:     begin on_ms = 100; off_ms = 100; count = 0;  end
      ST_ANSWERED:    begin on_ms = 120; off_ms = 120; count = 6;  end
      ST_CANCELLED:   begin on_ms = 400; off_ms = 400; count = 4;  end
      ST_FAILED:      begin on_ms = 80;  off_ms = 80;  count = 10; end
      default:        begin on_ms = 0;   off_ms = 0;   count = 0;  end
    endcase
  endfunction

  function automatic void enter_help(input state_e st);
    help     = st;
    phase_ms = 0;
    rounds   = '0;
    led_on   = (st != ST_IDLE);
  endfunction

  // advances the LED pattern by one tick, returns 1 when a blink run ends
  function automatic logic step_pattern();
    int unsigned on_ms, off_ms, count;
    blink_shape(help, on_ms, off_ms, count);
    phase_ms = phase_ms + tick_ms;
    if (phase_ms > PhaseSat) phase_ms = PhaseSat;
    if (help == ST_IDLE) begin
      led_on = 1'b0;
    end else if (help == ST_ACCEPTED) begin
      led_on = 1'b1;
    end else if (led_on) begin
      if (phase_ms >= on_ms) begin
        led_on   = 1'b0;
        phase_ms = 0;
      end
    end else if (phase_ms >= off_ms) begin
      if (count > 0) begin
        rounds = rounds + 4'd1;
        if (rounds >= count) begin
          enter_help(ST_IDLE);
          return 1'b1;
        end
      end
      led_on   = 1'b1;
      phase_ms = 0;
    end
    return 1'b0;
  endfunction

  function automatic led_expect_t predict_item(input logic cmd, input logic raw,
                                               input logic [2:0] ns);
    led_expect_t e;
    e.action  = ACT_NONE;
    e.changed = 1'b0;
    if (cmd == CMD_SET) begin
      if (ns < NumStates && ns != help) begin
        enter_help(state_e'(ns));
        e.changed = 1'b1;
      end
    end else begin
      if (!btn_level) begin
        held_ms = held_ms + tick_ms;
        if (held_ms > PressSat) held_ms = PressSat;
      end
      if (raw != pin_last) begin
        pin_last = raw;
        same_run = 1;
      end else if (same_run < SameSat) begin
        same_run++;
      end
      if (same_run == db_need && btn_level != raw) begin
        btn_level = raw;
        if (!raw) begin
          held_ms = 0;
        end else if (held_ms >= long_ms) begin
          e.action = ACT_RESEND;
        end else if (held_ms >= min_ms) begin
          e.action = (help == ST_IDLE) ? ACT_REQUEST : ACT_CANCEL;
        end
      end
      e.changed = step_pattern();
    end
    e.led_lit = led_on;
    e.state   = help;
    return e;
  endfunction

  task automatic report(input string what);
    errors_o++;
    $display("%0t ns: result %0d: %s", $time, results_seen, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_need      = 3;
      long_ms      = 2000;
      min_ms       = 50;
      tick_ms      = 20;
      pin_last     = 1'b1;
      same_run     = 0;
      btn_level    = 1'b1;
      held_ms      = 0;
      help         = ST_IDLE;
      phase_ms     = 0;
      led_on       = 1'b0;
      rounds       = '0;
      results_seen = 0;
      errors_o     = 0;
      expected_q.delete();
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_DEBOUNCE:   db_need = cfg_wdata_i[6:0];
          CFG_LONG_PRESS: long_ms = cfg_wdata_i;
          CFG_MIN_PRESS:  min_ms  = cfg_wdata_i;
          CFG_TICK:       tick_ms = cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      if (item_i.valid && item_i.ready) begin
        expected_q.push_back(predict_item(item_i.command, item_i.raw_level,
                                          item_i.new_state));
      end
      if (result_i.valid && result_i.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (result_i.led_lit !== want.led_lit)
            report($sformatf("led_lit got %0b, want %0b", result_i.led_lit, want.led_lit));
          if (result_i.action !== want.action)
            report($sformatf("action got %0d, want %0d", result_i.action, want.action));
          if (result_i.current_state !== want.state)
            report($sformatf("current_state got %0d, want %0d",
                             result_i.current_state, want.state));
          if (result_i.state_changed !== want.changed)
            report($sformatf("state_changed got %0b, want %0b",
                             result_i.state_changed, want.changed));
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the button debounce and LED pattern block with directed items, then
// with random button presses, bounces, noise and state commands under several
// register settings, with random gaps and result stalls. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bdlp_pkg::*;

  localparam int unsigned ItemTarget   = 1750;
  localparam logic [2:0]  StateUnknown = 3'd7;

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            cfg_we;
  cfg_idx_e        cfg_idx;
  logic [CfgW-1:0] cfg_wdata;

  bit              steady = 1'b0;
  int unsigned     items_sent = 0;
  int unsigned     cfg_db, cfg_long, cfg_min, cfg_tick;
  int unsigned     errors, pending;

  bdlp_in_if  item_ch ();
  bdlp_out_if result_ch ();

  button_debounce_led_pattern dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_ch),
    .result_o    (result_ch)
  );

  bdlp_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_ch),
    .result_i    (result_ch),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_item(input cmd_e cmd, input logic raw, input logic [2:0] ns);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_ch.valid     <= 1'b1;
    item_ch.command   <= cmd;
    item_ch.raw_level <= raw;
    item_ch.new_state <= ns;
    do @(posedge clk_i); while (!item_ch.ready);
    items_sent++;
  endtask

  task automatic tick(input logic raw);
    send_item(CMD_TICK, raw, 3'($urandom_range(0, 7)));
  endtask

  task automatic set_state(input logic [2:0] ns);
    send_item(CMD_SET, 1'($urandom_range(0, 1)), ns);
  endtask

  // stop sending and wait until every result has come back
  task automatic drain();
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CfgW'(val);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(input int unsigned db, input int unsigned lp,
                           input int unsigned mp, input int unsigned tk);
    write_reg(CFG_DEBOUNCE, db);
    write_reg(CFG_LONG_PRESS, lp);
    write_reg(CFG_MIN_PRESS, mp);
    write_reg(CFG_TICK, tk);
    cfg_db   = db;
    cfg_long = lp;
    cfg_min  = mp;
    cfg_tick = tk;
  endtask

  // result side: random stalls, with stretches of none
  initial begin : result_sink
    int unsigned stall;
    result_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned budget, base, t, hold, kind;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_DEBOUNCE;
    cfg_wdata         = '0;
    item_ch.valid     = 1'b0;
    item_ch.command   = CMD_TICK;
    item_ch.raw_level = 1'b1;
    item_ch.new_state = 3'd0;
    cfg_db   = 3;
    cfg_long = 2000;
    cfg_min  = 50;
    cfg_tick = 20;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset settings
    set_state(ST_ACCEPTED);
    set_state(ST_ACCEPTED);
    set_state(StateUnknown);
    repeat (3) tick(1'b0);
    repeat (3) tick(1'b1);   // short press while busy: cancel
    set_state(ST_LOCAL_ACKED);
    set_state(ST_SENDING);
    set_state(ST_ANSWERED);
    set_state(ST_CANCELLED);
    set_state(ST_FAILED);
    set_state(ST_IDLE);
    repeat (3) tick(1'b0);
    repeat (3) tick(1'b1);   // short press while idle: request
    tick(1'b0);
    tick(1'b1);              // bounce too short to debounce
    set_state(ST_FAILED);
    tick(1'b1);
    drain();

    for (int p = 0; items_sent < ItemTarget; p++) begin
      case (p)
        0: configure(3, 2000, 50, 20);
        1: configure(1, 0, 0, 1);
        2: configure(100, 65535, 65535, 100);
        3: configure(2, 5, 0, 0);
        4: configure(0, $urandom_range(0, 600), $urandom_range(0, 100),
                     $urandom_range(1, 100));
        5: configure(127, $urandom_range(0, 600), $urandom_range(0, 100),
                     $urandom_range(1, 100));
        default: configure($urandom_range(1, 6), $urandom_range(0, 3000),
                           $urandom_range(0, 400), $urandom_range(1, 100));
      endcase
      budget = items_sent + ((p >= 2 && p <= 5) ? 60 : 220);
      if (p == 2) begin
        // press held past the press-time ceiling, then released
        repeat (700) tick(1'b0);
        repeat (105) tick(1'b1);
        budget = items_sent + 60;
      end
      while (items_sent < budget) begin
        kind = $urandom_range(0, 9);
        t    = (cfg_tick == 0) ? 1 : cfg_tick;
        base = (cfg_db >= 1 && cfg_db <= 100) ? cfg_db : 1;
        if (kind < 6) begin
          // press lengths cluster around the glitch and long-press thresholds
          case ($urandom_range(0, 3))
            0:       hold = $urandom_range(1, 3);
            1:       hold = cfg_min / t + $urandom_range(0, 2);
            2:       hold = cfg_long / t + $urandom_range(0, 2);
            default: hold = $urandom_range(1, 40);
          endcase
          if (hold > 300) hold = $urandom_range(1, 40);
          hold = (hold > 1) ? hold - 1 : 1;
          if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              tick(1'b0);
              tick(1'b1);
            end
          end
          repeat (base - 1 + hold) tick(1'b0);
          if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              tick(1'b1);
              tick(1'b0);
            end
          end
          repeat (base + $urandom_range(0, 8)) tick(1'b1);
        end else if (kind < 8) begin
          set_state(3'($urandom_range(0, 7)));
          if ($urandom_range(0, 3) == 0) repeat ($urandom_range(60, 180)) tick(1'b1);
          else repeat ($urandom_range(0, 20)) tick(1'b1);
        end else begin
          repeat ($urandom_range(1, 10)) tick(1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 11) == 0) steady = !steady;
      end
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
